>>> hw/rtl/rab_pkg.sv
// rab_pkg: shared constants and types for the residual add buffer
// no dependencies; used by the interfaces, residual_add_buffer and the bench
package rab_pkg;

   localparam int LANES_DEF       = 8;
   localparam int STORE_DEPTH_DEF = 512;
   localparam int ELEM_WIDTH_DEF  = 16;

   localparam int LC_W       = 8;
   localparam int WC_W       = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [LC_W-1:0] LC_RESET = 8'd1;
   localparam logic [WC_W-1:0] WC_RESET = 10'd320;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LAYER_COUNT = 1'b0,
      CSR_WORD_COUNT  = 1'b1
   } csr_index_type;

endpackage

>>> hw/rtl/rab_req_if.sv
// rab_req_if: input vector channel (valid/ready plus one lane per element)
// depends on rab_pkg for default sizes
interface rab_req_if #(
   parameter int LANES      = rab_pkg::LANES_DEF,
   parameter int ELEM_WIDTH = rab_pkg::ELEM_WIDTH_DEF
);
   typedef logic signed [ELEM_WIDTH-1:0] elem_type;

   logic                 valid;
   logic                 ready;
   elem_type [LANES-1:0] lane;

   modport source (output valid, output lane, input ready);
   modport sink   (input valid, input lane, output ready);
endinterface

>>> hw/rtl/rab_rsp_if.sv
// rab_rsp_if: result channel (kind, updated buffer word, last flag)
// depends on rab_pkg for default sizes
interface rab_rsp_if #(
   parameter int LANES      = rab_pkg::LANES_DEF,
   parameter int ELEM_WIDTH = rab_pkg::ELEM_WIDTH_DEF
);
   typedef logic signed [ELEM_WIDTH-1:0] elem_type;

   logic                 valid;
   logic                 ready;
   logic                 kind;
   elem_type [LANES-1:0] out;
   logic                 last;

   modport source (output valid, output kind, output out, output last, input ready);
   modport sink   (input valid, input kind, input out, input last, output ready);
endinterface

>>> hw/rtl/rab_lane.sv
// rab_lane: one element lane, passes the loaded value or adds the residual
// standalone; instantiated once per lane by residual_add_buffer
module rab_lane #(
   parameter int ELEM_WIDTH = 16
) (
   input  logic                  loading,
   input  logic [ELEM_WIDTH-1:0] stored,
   input  logic [ELEM_WIDTH-1:0] din,
   output logic [ELEM_WIDTH-1:0] result
);

   // sum wraps at the element width
   assign result = loading ? din : ELEM_WIDTH'(stored + din);

endmodule

>>> hw/rtl/rab_store.sv
// rab_store: activation buffer, one write port and one registered read port
// standalone; instantiated by residual_add_buffer
module rab_store #(
   parameter int DEPTH  = 512,
   parameter int IDX_W  = 9,
   parameter int DATA_W = 128
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/residual_add_buffer.sv
// residual_add_buffer: top level, sequencer, lane array and result register
// depends on rab_pkg, rab_req_if, rab_rsp_if, rab_lane and rab_store
//
//   channel   dir   handshake       contents
//   req_bus   in    valid/ready     LANES signed elements (activation or residual)
//   rsp_bus   out   valid/ready     kind, LANES updated elements, last
//   csr_*     in    csr_we          csr_index selects layer_count or word_count
//
// per item: the accept cycle reads the buffer word, then the exec state adds in
// all lanes, writes the word back and loads the result register. the exec state
// exists because the buffer read is registered; no item is accepted during it.
// a waiting result does not block the next accept; only the add cycle stalls
// until the result register is free.
// reset (synchronous) returns to the load phase; the buffer is not cleared.
module residual_add_buffer #(
   parameter int LANES       = rab_pkg::LANES_DEF,
   parameter int STORE_DEPTH = rab_pkg::STORE_DEPTH_DEF,
   parameter int ELEM_WIDTH  = rab_pkg::ELEM_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   rab_req_if.sink                        req_bus,
   rab_rsp_if.source                      rsp_bus,
   input  logic                           csr_we,
   input  logic [rab_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rab_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rab_pkg::*;

   localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > WC_W) ? CNT_W : WC_W;
   localparam int DATA_W = LANES * ELEM_WIDTH;

   typedef logic [LANES-1:0][ELEM_WIDTH-1:0] word_type;
   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type       state_ff;
   logic [IDX_W-1:0] word_index_ff;
   logic [LC_W-1:0] layer_index_ff;
   logic            loading_ff;
   logic [LC_W-1:0] layer_count_ff;
   logic [WC_W-1:0] word_count_ff;

   word_type        din_ff;
   logic [IDX_W-1:0] addr_ff;
   logic            op_load_ff;
   logic            op_final_ff;
   logic            op_last_ff;

   logic            rsp_valid_ff;
   logic            rsp_kind_ff;
   word_type        rsp_out_ff;
   logic            rsp_last_ff;

   logic [CMP_W-1:0] wc_ext;
   logic [CMP_W-1:0] words;
   logic [CMP_W-1:0] widx_ext;
   logic [CMP_W-1:0] w_sel;
   logic [IDX_W-1:0] addr_in;
   logic            is_last;
   logic            final_pass;
   logic            accept;
   logic            out_free;
   logic            commit;
   word_type        rd_word;
   word_type        sum_word;

   // effective word count: zero acts as one, clipped to the buffer depth
   always_comb begin
      wc_ext = CMP_W'(word_count_ff);
      if (wc_ext == '0) begin
         words = CMP_W'(1);
      end else if (wc_ext > CMP_W'(STORE_DEPTH)) begin
         words = CMP_W'(STORE_DEPTH);
      end else begin
         words = wc_ext;
      end
      widx_ext = CMP_W'(word_index_ff);
      w_sel    = (widx_ext >= words) ? CMP_W'(words - CMP_W'(1)) : widx_ext;
      addr_in  = w_sel[IDX_W-1:0];
      is_last  = (w_sel == CMP_W'(words - CMP_W'(1)));
      if (loading_ff) begin
         final_pass = (layer_count_ff == '0);
      end else begin
         final_pass = ({1'b0, layer_index_ff} + (LC_W+1)'(1)) >= {1'b0, layer_count_ff};
      end
   end

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign commit   = (state_ff == S_EXEC) && out_free;

   assign req_bus.ready = (state_ff == S_IDLE);

   rab_store #(
      .DEPTH  (STORE_DEPTH),
      .IDX_W  (IDX_W),
      .DATA_W (DATA_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (addr_ff),
      .wr_data (sum_word),
      .rd_en   (accept),
      .rd_addr (addr_in),
      .rd_data (rd_word)
   );

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      rab_lane #(
         .ELEM_WIDTH (ELEM_WIDTH)
      ) u_lane (
         .loading (op_load_ff),
         .stored  (rd_word[i]),
         .din     (din_ff[i]),
         .result  (sum_word[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         word_index_ff  <= '0;
         layer_index_ff <= '0;
         loading_ff     <= 1'b1;
         layer_count_ff <= LC_RESET;
         word_count_ff  <= WC_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_LAYER_COUNT: layer_count_ff <= csr_wdata[LC_W-1:0];
               CSR_WORD_COUNT:  word_count_ff  <= csr_wdata[WC_W-1:0];
               default: ;
            endcase
         end

         // a new result beat replaces the one leaving in the same cycle
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_EXEC;
                  if (is_last) begin
                     word_index_ff <= '0;
                     if (final_pass) begin
                        loading_ff     <= 1'b1;
                        layer_index_ff <= '0;
                     end else if (loading_ff) begin
                        loading_ff     <= 1'b0;
                        layer_index_ff <= '0;
                     end else begin
                        layer_index_ff <= LC_W'(layer_index_ff + LC_W'(1));
                     end
                  end else begin
                     word_index_ff <= IDX_W'(addr_in + IDX_W'(1));
                  end
               end
            end
            S_EXEC: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // operand and result beat registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         din_ff      <= req_bus.lane;
         addr_ff     <= addr_in;
         op_load_ff  <= loading_ff;
         op_final_ff <= final_pass;
         op_last_ff  <= is_last;
      end
      if (commit) begin
         rsp_kind_ff <= op_final_ff;
         rsp_out_ff  <= sum_word;
         rsp_last_ff <= op_last_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.kind  = rsp_kind_ff;
   assign rsp_bus.out   = rsp_out_ff;
   assign rsp_bus.last  = rsp_last_ff;

endmodule

>>> verif/residual_add_buffer_tb.sv
// residual_add_buffer_tb: self-checking bench for the residual add buffer
// drives vector beats and register writes, predicts every result beat and compares
// depends on rab_pkg, rab_req_if, rab_rsp_if and residual_add_buffer
`timescale 1ns / 1ps

module residual_add_buffer_tb;
   import rab_pkg::*;

   localparam int NL         = LANES_DEF;
   localparam int EW         = ELEM_WIDTH_DEF;
   localparam int DEPTH      = STORE_DEPTH_DEF;
   localparam int RAND_ITEMS = 1100;
   localparam int IDLE_LIMIT = 1000;
   localparam int SETTLE     = 10;
   localparam int RUN_CAP    = 60;

   localparam logic [EW-1:0] ELEM_MAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic [EW-1:0] ELEM_MIN = {1'b1, {(EW-1){1'b0}}};

   typedef logic [NL-1:0][EW-1:0] vec_type;
   typedef struct packed {
      logic    kind;
      vec_type out;
      logic    last;
   } beat_type;
   typedef struct {
      bit       fixed;
      beat_type word;
   } pin_type;
   typedef struct {
      bit                    is_cfg;
      csr_index_type         idx;
      logic [CSR_DATA_W-1:0] val;
      vec_type               v;
      bit                    fixed;
      beat_type              word;
   } step_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rab_req_if req_bus();
   rab_rsp_if rsp_bus();

   residual_add_buffer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   vec_type         buffer_img [DEPTH];
   int unsigned     word_pos;
   logic [7:0]      layer_pos;
   bit              loading_phase;
   logic [LC_W-1:0] layers;
   logic [WC_W-1:0] words_cfg;

   beat_type due_words[$];
   pin_type  pins[$];
   step_type steps[$];
   int       errors;
   int       idle_cycles;
   int       src_gap_pct;
   int       sink_stall_pct;
   int       stall_left;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] mismatch %0d: %s", $time, errors, msg);
   endtask

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic int unsigned active_words();
      int unsigned n;
      n = 32'(words_cfg);
      if (n == 0) n = 1;
      if (n > DEPTH) n = DEPTH;
      return n;
   endfunction

   // one accepted vector: update the buffer image and return the result beat
   function automatic beat_type apply_vector(vec_type v);
      int unsigned n;
      int unsigned w;
      logic        closing;
      logic        at_end;
      beat_type    r;
      n = active_words();
      w = (word_pos >= n) ? n - 1 : word_pos;
      if (loading_phase) begin
         closing = (layers == 0);
         buffer_img[w] = v;
      end else begin
         closing = (int'(layer_pos) + 1 >= int'(layers));
         for (int i = 0; i < NL; i++) buffer_img[w][i] = buffer_img[w][i] + v[i];
      end
      at_end = (w + 1 >= n);
      r.kind = closing;
      r.out  = buffer_img[w];
      r.last = at_end;
      if (at_end) begin
         word_pos = 0;
         if (closing) begin
            loading_phase = 1'b1;
            layer_pos     = '0;
         end else if (loading_phase) begin
            loading_phase = 1'b0;
            layer_pos     = '0;
         end else begin
            layer_pos = layer_pos + 1'b1;
         end
      end else begin
         word_pos = w + 1;
      end
      return r;
   endfunction

   // beats left until the current run returns to its load phase
   function automatic int unsigned words_to_run_end();
      int unsigned n;
      int unsigned w;
      int unsigned rem;
      n   = active_words();
      w   = (word_pos >= n) ? n - 1 : word_pos;
      rem = n - w;
      if (loading_phase) return (layers == 0) ? rem : rem + n * 32'(layers);
      if (int'(layer_pos) + 1 >= int'(layers)) return rem;
      return rem + n * 32'(int'(layers) - 1 - int'(layer_pos));
   endfunction

   function automatic vec_type rand_vec();
      vec_type v;
      for (int i = 0; i < NL; i++) begin
         case ($urandom_range(0, 9))
            0: v[i] = ELEM_MAX;
            1: v[i] = ELEM_MIN;
            2: v[i] = '0;
            3: v[i] = '1;
            default: v[i] = EW'($urandom);
         endcase
      end
      return v;
   endfunction

   function automatic void add_cfg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      step_type s;
      s.is_cfg = 1'b1;
      s.idx    = idx;
      s.val    = val;
      steps.push_back(s);
   endfunction

   // a pinned row carries its result, which always echoes the loaded word
   function automatic void add_vec(vec_type v, bit fixed = 0, logic kind = 0, logic last = 0);
      step_type s;
      s.is_cfg    = 1'b0;
      s.v         = v;
      s.fixed     = fixed;
      s.word.kind = kind;
      s.word.out  = v;
      s.word.last = last;
      steps.push_back(s);
   endfunction

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_LAYER_COUNT) layers = val[LC_W-1:0];
      else words_cfg = val[WC_W-1:0];
   endtask

   task automatic send_beat(vec_type v, bit fixed, beat_type word);
      pin_type pin;
      int      gap;
      pin.fixed = fixed;
      pin.word  = word;
      pins.push_back(pin);
      gap = ($urandom_range(0, 99) < src_gap_pct) ? pick_gap() : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.lane  <= v;
      req_bus.valid <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // hold the sender until every expected beat is back, then let the block settle
   task automatic drain_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (due_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left == 0 && $urandom_range(0, 99) < sink_stall_pct) stall_left = pick_gap();
      if (stall_left != 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      pin_type  pin;
      beat_type predicted;
      beat_type got;
      beat_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predicted = apply_vector(req_bus.lane);
            pin.fixed = 1'b0;
            if (pins.size() != 0) pin = pins.pop_front();
            due_words.push_back(pin.fixed ? pin.word : predicted);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.kind = rsp_bus.kind;
            got.out  = rsp_bus.out;
            got.last = rsp_bus.last;
            if (due_words.size() == 0) begin
               report("result beat with nothing expected");
            end else begin
               want = due_words.pop_front();
               if (got.kind !== want.kind)
                  report($sformatf("kind got %0b want %0b", got.kind, want.kind));
               for (int i = 0; i < NL; i++) begin
                  if (got.out[i] !== want.out[i])
                     report($sformatf("lane %0d got %h want %h", i, got.out[i], want.out[i]));
               end
               if (got.last !== want.last)
                  report($sformatf("last got %0b want %0b", got.last, want.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_we)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("residual_add_buffer verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      int                    sent;
      int                    n;
      int                    r;
      logic [CSR_DATA_W-1:0] val;
      vec_type               a_vec;
      vec_type               b_vec;

      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = CSR_LAYER_COUNT;
      csr_wdata     = '0;
      req_bus.valid = 1'b0;
      req_bus.lane  = '0;
      rsp_bus.ready = 1'b0;
      errors        = 0;
      idle_cycles   = 0;
      stall_left    = 0;
      src_gap_pct    = 30;
      sink_stall_pct = 30;
      loading_phase = 1'b1;
      word_pos      = 0;
      layer_pos     = '0;
      layers        = LC_RESET;
      words_cfg     = WC_RESET;

      a_vec = {16'haaaa, 16'h5555, 16'hfffe, 16'h0001, 16'hffff, 16'h0000, ELEM_MIN, ELEM_MAX};
      b_vec = {16'h5555, 16'haaaa, 16'h0001, 16'hffff, ELEM_MIN, ELEM_MAX, 16'hffff, 16'h0001};

      // reset defaults: one layer, 320 words, load phase
      add_vec(a_vec, 1, 0, 0);
      // shrink the activation mid-load so the next word closes it
      add_cfg(CSR_WORD_COUNT, 2);
      add_vec(b_vec, 1, 0, 1);
      // only layer pass is the last one, sums wrap at the top of the range
      add_vec({NL{16'h0001}});
      add_vec('0);
      // no layers: load words come straight out as final words
      add_cfg(CSR_LAYER_COUNT, 0);
      add_vec({NL{ELEM_MAX}}, 1, 1, 0);
      add_vec({NL{ELEM_MIN}}, 1, 1, 1);
      // word count of zero behaves as one
      add_cfg(CSR_WORD_COUNT, 0);
      add_vec('1, 1, 1, 1);
      add_cfg(CSR_LAYER_COUNT, 3);
      add_cfg(CSR_WORD_COUNT, 3);
      add_vec(a_vec);
      add_vec(b_vec);
      add_vec({NL{ELEM_MAX}});
      add_vec({NL{16'h0001}});
      // word position already past the new count: pass ends on this word
      add_cfg(CSR_WORD_COUNT, 1);
      add_vec('1);
      // layer position past the new layer count: this pass becomes the last
      add_cfg(CSR_LAYER_COUNT, 1);
      add_vec({NL{ELEM_MIN}});

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[k]) begin
         if (steps[k].is_cfg) begin
            drain_idle();
            write_csr(steps[k].idx, steps[k].val);
         end else begin
            send_beat(steps[k].v, steps[k].fixed, steps[k].word);
         end
      end

      // full-depth load with an oversized word count; fills every buffer entry
      drain_idle();
      write_csr(CSR_LAYER_COUNT, 0);
      write_csr(CSR_WORD_COUNT, 1023);
      n = int'(words_to_run_end());
      repeat (n) send_beat(rand_vec(), 1'b0, '0);
      sent = n;

      // deepest layer count on a one-word activation
      drain_idle();
      write_csr(CSR_LAYER_COUNT, 255);
      write_csr(CSR_WORD_COUNT, 1);
      n = int'(words_to_run_end());
      repeat (n) send_beat(rand_vec(), 1'b0, '0);
      sent += n;

      // every entry now holds data, so mid-run register changes are safe
      while (sent < RAND_ITEMS) begin
         drain_idle();
         src_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
         sink_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
         if ($urandom_range(0, 9) < 6) begin
            r = $urandom_range(0, 9);
            if (r < 7) val = CSR_DATA_W'($urandom_range(0, 4));
            else if (r == 7) val = 255;
            else if (r == 8) val = CSR_DATA_W'($urandom_range(5, 254));
            else val = 0;
            write_csr(CSR_LAYER_COUNT, val);
         end
         if ($urandom_range(0, 9) < 6) begin
            r = $urandom_range(0, 9);
            if (r < 6) val = CSR_DATA_W'($urandom_range(1, 8));
            else if (r == 6) val = 0;
            else if (r == 7) val = CSR_DATA_W'($urandom_range(9, 40));
            else if (r == 8) val = CSR_DATA_W'(DEPTH);
            else val = CSR_DATA_W'($urandom_range(DEPTH + 1, 1023));
            write_csr(CSR_WORD_COUNT, val);
         end
         n = $urandom_range(0, 1) ? int'(words_to_run_end()) : int'($urandom_range(1, 30));
         if (n > RUN_CAP) n = RUN_CAP;
         repeat (n) send_beat(rand_vec(), 1'b0, '0);
         sent += n;
      end

      drain_idle();
      repeat (SETTLE) @(posedge clock);
      if (due_words.size() != 0) report("result beats still outstanding");
      if (errors == 0)
         $display("residual_add_buffer verification clean");
      else
         $display("residual_add_buffer verification failed");
      $finish;
   end

endmodule
